// ===== hw/rtl/fnvh_pkg.sv =====
// ----------------------------------------------------------------------------
// fnvh_pkg
// Shared types, constants and byte helpers for the FNV-1 string hash engine.
// ----------------------------------------------------------------------------
package fnvh_pkg;

	// Hash mode codes
	localparam logic [1:0] MODE_32   = 2'd0;
	localparam logic [1:0] MODE_64   = 2'd1;
	localparam logic [1:0] MODE_CLIP = 2'd2;
	localparam logic [1:0] MODE_ALT  = 2'd3;

	// Configuration register indexes
	localparam logic REG_HASH_MODE = 1'b0;
	localparam logic REG_FOLD_CASE = 1'b1;

	// Prefix kinds
	localparam logic [1:0] KIND_UNDEC = 2'd0;
	localparam logic [1:0] KIND_NONE  = 2'd1;
	localparam logic [1:0] KIND_X     = 2'd2;
	localparam logic [1:0] KIND_XY    = 2'd3;

	// FNV constants (prime split into a high power of two plus a low part)
	localparam logic [31:0] BASIS32     = 32'h811C9DC5;
	localparam logic [63:0] BASIS64     = 64'hCBF29CE484222325;
	localparam logic [8:0]  PRIME32_LO  = 9'h193;
	localparam int          PRIME32_SH  = 24;
	localparam logic [8:0]  PRIME64_LO  = 9'h1B3;
	localparam int          PRIME64_SH  = 40;
	localparam logic [63:0] LOW48       = 64'h0000FFFFFFFFFFFF;

	// Characters
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_Z = 8'h5A;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_Z    = 8'h7A;
	localparam logic [7:0] CH_O    = 8'h6F;
	localparam logic [7:0] CH_B    = 8'h62;
	localparam logic [7:0] CH_P    = 8'h70;
	localparam logic [7:0] CH_C    = 8'h63;
	localparam logic [7:0] CH_T    = 8'h74;
	localparam logic [7:0] CH_H    = 8'h68;
	localparam logic [7:0] CH_E    = 8'h65;
	localparam logic [7:0] CH_TWO  = 8'h32;
	localparam logic [7:0] CH_US   = 8'h5F;

	// Age codes
	localparam logic [7:0] AGE_B = 8'h01;
	localparam logic [7:0] AGE_P = 8'h02;
	localparam logic [7:0] AGE_C = 8'h03;
	localparam logic [7:0] AGE_T = 8'h04;
	localparam logic [7:0] AGE_H = 8'h05;
	localparam logic [7:0] AGE_E = 8'h06;
	localparam logic [7:0] AGE_NONE = 8'h00;

	// Prefix buffer control and status
	typedef struct packed {
		logic clr;
		logic wr;
		logic decide;
	} pfx_ctl_t;

	typedef struct packed {
		logic [2:0] count;
		logic [1:0] kind;
	} pfx_sts_t;

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= CH_UP_A && b <= CH_UP_Z) begin
			r = b | 8'h20;
		end
		return r;
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= CH_A) && (b <= CH_Z);
	endfunction

	function automatic logic is_default_age(input logic [7:0] b);
		return (b == CH_A) || (b == CH_O);
	endfunction

	function automatic logic [7:0] age_code(input logic [7:0] b);
		logic [7:0] r;
		r = AGE_NONE;
		if (b == CH_B) r = AGE_B;
		if (b == CH_P) r = AGE_P;
		if (b == CH_C) r = AGE_C;
		if (b == CH_T) r = AGE_T;
		if (b == CH_H) r = AGE_H;
		if (b == CH_E) r = AGE_E;
		return r;
	endfunction

	function automatic logic [63:0] basis(input logic [1:0] mode);
		return (mode == MODE_32) ? {32'd0, BASIS32} : BASIS64;
	endfunction

endpackage

// ===== hw/rtl/fnvh_mix.sv =====
// ----------------------------------------------------------------------------
// fnvh_mix
// Shared FNV-1 round: multiply the accumulator by the prime, then XOR a byte.
// ----------------------------------------------------------------------------
module fnvh_mix (
	input  logic [63:0] acc,
	input  logic [7:0]  data,
	input  logic        is32,
	output logic [63:0] acc_next
);

	logic [63:0] prod64;
	logic [31:0] prod32;

	// Prime is 2^k plus a small constant: one shift plus a narrow multiply
	always_comb begin
		prod64 = (acc << fnvh_pkg::PRIME64_SH) + acc * {55'd0, fnvh_pkg::PRIME64_LO};
		prod32 = (acc[31:0] << fnvh_pkg::PRIME32_SH)
			+ acc[31:0] * {23'd0, fnvh_pkg::PRIME32_LO};
		if (is32) begin
			acc_next = {32'd0, prod32 ^ {24'd0, data}};
		end else begin
			acc_next = prod64 ^ {56'd0, data};
		end
	end

endmodule

// ===== hw/rtl/fnvh_prefix.sv =====
// ----------------------------------------------------------------------------
// fnvh_prefix
// Clip-name prefix buffer: holds the first four bytes, decides the prefix
// kind, supplies replay bytes with age substitution and applies the age tag.
// ----------------------------------------------------------------------------
module fnvh_prefix (
	input  logic               clk,
	input  logic               arst_n,
	input  fnvh_pkg::pfx_ctl_t ctl,
	input  logic [7:0]         wr_byte,
	input  logic [1:0]         ridx,
	input  logic [63:0]        hash_in,
	output fnvh_pkg::pfx_sts_t sts,
	output logic [7:0]         replay_byte,
	output logic [63:0]        clip_hash
);

	logic [7:0] pfx_q [4];
	logic [2:0] count_q;
	logic [1:0] kind_q;
	logic [1:0] kind_dec;
	logic [7:0] rb;
	logic       xdef;
	logic       ydef;
	logic [7:0] px;
	logic [7:0] py;
	logic [63:0] h;

	// Store buffered bytes (no reset, read only after written)
	always_ff @(posedge clk) begin
		if (ctl.wr && !ctl.clr) begin
			pfx_q[count_q[1:0]] <= wr_byte;
		end
	end

	// Track fill count and decided kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd0;
			kind_q  <= fnvh_pkg::KIND_UNDEC;
		end else if (ctl.clr) begin
			count_q <= 3'd0;
			kind_q  <= fnvh_pkg::KIND_UNDEC;
		end else begin
			if (ctl.wr) begin
				count_q <= count_q + 3'd1;
			end
			if (ctl.decide) begin
				kind_q <= kind_dec;
			end
		end
	end

	// Decide prefix from the bytes present
	always_comb begin
		if (count_q == 3'd4 && pfx_q[1] == fnvh_pkg::CH_TWO && pfx_q[3] == fnvh_pkg::CH_US
			&& fnvh_pkg::is_letter(pfx_q[0]) && fnvh_pkg::is_letter(pfx_q[2])) begin
			kind_dec = fnvh_pkg::KIND_XY;
		end else if (count_q >= 3'd2 && pfx_q[1] == fnvh_pkg::CH_US
			&& fnvh_pkg::is_letter(pfx_q[0])) begin
			kind_dec = fnvh_pkg::KIND_X;
		end else begin
			kind_dec = fnvh_pkg::KIND_NONE;
		end
	end

	// Replace a non-default age letter by 'a' on replay
	always_comb begin
		rb = pfx_q[ridx];
		replay_byte = rb;
		if (!fnvh_pkg::is_default_age(rb)) begin
			if (ridx == 2'd0 && (kind_q == fnvh_pkg::KIND_X || kind_q == fnvh_pkg::KIND_XY)) begin
				replay_byte = fnvh_pkg::CH_A;
			end
			if (ridx == 2'd2 && kind_q == fnvh_pkg::KIND_XY) begin
				replay_byte = fnvh_pkg::CH_A;
			end
		end
	end

	// Apply age tag to the final hash
	always_comb begin
		xdef = fnvh_pkg::is_default_age(pfx_q[0]);
		ydef = (kind_q == fnvh_pkg::KIND_XY) ? fnvh_pkg::is_default_age(pfx_q[2]) : 1'b1;
		px   = xdef ? fnvh_pkg::AGE_NONE : fnvh_pkg::age_code(pfx_q[0]);
		py   = ydef ? fnvh_pkg::AGE_NONE : fnvh_pkg::age_code(pfx_q[2]);
		h    = hash_in;
		if (kind_q == fnvh_pkg::KIND_X || kind_q == fnvh_pkg::KIND_XY) begin
			if (xdef && ydef) begin
				h = {1'b0, hash_in[62:0]};
			end else begin
				h = (hash_in & fnvh_pkg::LOW48)
					| {{1'b1, hash_in[62:56]} ^ px, hash_in[55:48] ^ py, 48'd0};
			end
		end
		clip_hash = h;
	end

	assign sts.count = count_q;
	assign sts.kind  = kind_q;

endmodule

// ===== hw/rtl/fnv1_string_hash_engine.sv =====
// ----------------------------------------------------------------------------
// fnv1_string_hash_engine
// FNV-1 32/64-bit string hash with optional case folding and a 64-bit
// clip-name mode that recognizes and tags age prefixes.
// ----------------------------------------------------------------------------
//
//  channel  handshake            payload
//  in       in_valid/in_ready    data_byte, has_byte, is_last
//  out      out_valid/out_ready  hash_value
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A word is accepted in the idle state and then passes through the shared mix
// unit; a last word then loads the output register. In clip mode the fourth
// byte or a short name adds a decide step and a mix step for each buffered
// byte (up to four). Reset leaves mode 64-bit, no case folding.
// A held result does not block input; a last word waits until it is taken.
module fnv1_string_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MIX    = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_REPLAY = 5'b01000,
		ST_FINAL  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [7:0]         byte_q;
	logic               has_q;
	logic               last_q;
	logic [63:0]        acc_q;
	logic [1:0]         mode_q;
	logic               fold_q;
	logic [1:0]         ridx_q;
	logic               out_valid_q;
	logic [63:0]        hash_q;

	logic               is32;
	logic               clip;
	logic               buffering;
	logic               in_acc;
	logic               cfg_mode_wr;
	logic               out_free;
	logic               fin_go;
	logic               go_decide;
	logic               replay_end;
	logic [7:0]         in_byte;
	logic [7:0]         mix_byte;
	logic [63:0]        mix_out;
	logic [63:0]        fin_hash;
	logic [7:0]         replay_byte;
	logic [63:0]        clip_hash;
	fnvh_pkg::pfx_ctl_t pctl;
	fnvh_pkg::pfx_sts_t pst;

	assign is32        = (mode_q == fnvh_pkg::MODE_32);
	assign clip        = (mode_q == fnvh_pkg::MODE_CLIP);
	assign buffering   = clip && (pst.kind == fnvh_pkg::KIND_UNDEC);
	assign in_ready    = (state_q == ST_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign cfg_ready   = 1'b1;
	assign cfg_mode_wr = cfg_valid && (cfg_index == fnvh_pkg::REG_HASH_MODE);
	assign out_free    = !out_valid_q || out_ready;
	assign fin_go      = (state_q == ST_FINAL) && out_free;
	assign go_decide   = buffering && (last_q || (has_q && pst.count == 3'd3));
	assign replay_end  = ({1'b0, ridx_q} == pst.count - 3'd1);
	assign out_valid   = out_valid_q;
	assign hash_value  = hash_q;

	// Fold case on entry: always in clip mode, on request otherwise
	assign in_byte = (clip || fold_q) ? fnvh_pkg::to_lower(data_byte) : data_byte;

	// Shared mix unit
	assign mix_byte = (state_q == ST_REPLAY) ? replay_byte : byte_q;

	fnvh_mix u_mix (
		.acc      (acc_q),
		.data     (mix_byte),
		.is32     (is32),
		.acc_next (mix_out)
	);

	// Prefix buffer control
	assign pctl.clr    = cfg_mode_wr || fin_go;
	assign pctl.wr     = (state_q == ST_MIX) && has_q && buffering;
	assign pctl.decide = (state_q == ST_DECIDE);

	fnvh_prefix u_prefix (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (pctl),
		.wr_byte     (byte_q),
		.ridx        (ridx_q),
		.hash_in     (acc_q),
		.sts         (pst),
		.replay_byte (replay_byte),
		.clip_hash   (clip_hash)
	);

	// Select final result by mode
	always_comb begin
		if (clip) begin
			fin_hash = clip_hash;
		end else if (is32) begin
			fin_hash = {32'd0, acc_q[31:0]};
		end else begin
			fin_hash = acc_q;
		end
	end

	// Hold the accepted word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_q <= in_byte;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= fnvh_pkg::MODE_64;
			fold_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == fnvh_pkg::REG_HASH_MODE) begin
				mode_q <= (cfg_data == fnvh_pkg::MODE_ALT) ? fnvh_pkg::MODE_64 : cfg_data;
			end else begin
				fold_q <= cfg_data[0];
			end
		end
	end

	// Accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= fnvh_pkg::BASIS64;
		end else if (cfg_mode_wr) begin
			acc_q <= fnvh_pkg::basis(cfg_data);
		end else if (fin_go) begin
			acc_q <= fnvh_pkg::basis(mode_q);
		end else if ((state_q == ST_MIX && has_q && !buffering) || state_q == ST_REPLAY) begin
			acc_q <= mix_out;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			has_q   <= 1'b0;
			last_q  <= 1'b0;
			ridx_q  <= 2'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						has_q   <= has_byte;
						last_q  <= is_last;
						state_q <= ST_MIX;
					end
				end
				ST_MIX: begin
					if (go_decide) begin
						state_q <= ST_DECIDE;
					end else if (last_q) begin
						state_q <= ST_FINAL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DECIDE: begin
					ridx_q <= 2'd0;
					if (pst.count != 3'd0) begin
						state_q <= ST_REPLAY;
					end else if (last_q) begin
						state_q <= ST_FINAL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_REPLAY: begin
					ridx_q <= ridx_q + 2'd1;
					if (replay_end) begin
						state_q <= last_q ? ST_FINAL : ST_IDLE;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: load on final, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			hash_q <= fin_hash;
		end
	end

`ifndef SYNTH
	ap_accept_to_mix: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_MIX))
		else $error("accepted word did not enter the mix step");

	ap_replay_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPLAY) |-> ({1'b0, ridx_q} < pst.count))
		else $error("replay index beyond buffered bytes");

	ap_kind_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pst.kind == fnvh_pkg::KIND_X || pst.kind == fnvh_pkg::KIND_XY) |-> (pst.count >= 3'd2))
		else $error("age prefix decided with too few bytes");

	ap_kind_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(pst.kind != fnvh_pkg::KIND_UNDEC) |-> clip)
		else $error("prefix kind set outside clip mode");

	ap_out_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINAL))
		else $error("result raised outside final step");
`endif

endmodule

// ===== verif/fnv1_hash_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fnv1_hash_checker
// Watches the input, output and register channels of the FNV-1 string hash
// engine, keeps its own copy of the hash state, queues the hash due for each
// name end and compares every taken output word against the oldest one.
// ----------------------------------------------------------------------------
module fnv1_hash_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] hash_value,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	output int          fail_count,
	output int          hashes_due
);

	localparam logic [31:0] FNV_PRIME32 = 32'h01000193;
	localparam logic [63:0] FNV_PRIME64 = 64'h00000100000001B3;

	// Shadow registers and name state
	logic [1:0]  mode_q;
	logic        fold_q;
	logic [63:0] acc;
	logic [7:0]  pfx [4];
	logic [2:0]  nbytes;
	logic [1:0]  kind;
	logic [63:0] hash_fifo [$];

	initial fail_count = 0;
	initial hashes_due = 0;

	function automatic logic [1:0] live_mode(input logic [1:0] m);
		return (m == fnvh_pkg::MODE_ALT) ? fnvh_pkg::MODE_64 : m;
	endfunction

	function automatic logic [7:0] fold_lc(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
	endfunction

	function automatic logic alpha_lc(input logic [7:0] b);
		return b >= 8'h61 && b <= 8'h7A;
	endfunction

	// 'a' and 'o' are the ages that carry no tag
	function automatic logic plain_age(input logic [7:0] b);
		return b == 8'h61 || b == 8'h6F;
	endfunction

	function automatic logic [7:0] age_tag(input logic [7:0] b);
		case (b)
			8'h62:   return 8'h01;
			8'h70:   return 8'h02;
			8'h63:   return 8'h03;
			8'h74:   return 8'h04;
			8'h68:   return 8'h05;
			8'h65:   return 8'h06;
			default: return 8'h00;
		endcase
	endfunction

	// Drop any partial name and reload the basis of the current mode
	task automatic restart_name();
		acc = (live_mode(mode_q) == fnvh_pkg::MODE_32) ? {32'd0, fnvh_pkg::BASIS32}
			: fnvh_pkg::BASIS64;
		for (int i = 0; i < 4; i++) begin
			pfx[i] = 8'h00;
		end
		nbytes = 3'd0;
		kind = fnvh_pkg::KIND_UNDEC;
	endtask

	task automatic mix_byte(input logic [7:0] b);
		logic [31:0] p32;
		if (live_mode(mode_q) == fnvh_pkg::MODE_32) begin
			p32 = acc[31:0] * FNV_PRIME32;
			acc = {32'd0, p32 ^ {24'd0, b}};
		end else begin
			acc = (acc * FNV_PRIME64) ^ {56'd0, b};
		end
	endtask

	// Classify the buffered head of a clip name, then hash it with ages replaced
	task automatic settle_prefix();
		int n;
		logic [7:0] b;
		n = (nbytes > 3'd4) ? 4 : int'(nbytes);
		if (n >= 4 && pfx[1] == fnvh_pkg::CH_TWO && pfx[3] == fnvh_pkg::CH_US &&
				alpha_lc(pfx[0]) && alpha_lc(pfx[2])) begin
			kind = fnvh_pkg::KIND_XY;
		end else if (n >= 2 && pfx[1] == fnvh_pkg::CH_US && alpha_lc(pfx[0])) begin
			kind = fnvh_pkg::KIND_X;
		end else begin
			kind = fnvh_pkg::KIND_NONE;
		end
		for (int i = 0; i < n; i++) begin
			b = pfx[i];
			if (((i == 0 && kind != fnvh_pkg::KIND_NONE) ||
					(i == 2 && kind == fnvh_pkg::KIND_XY)) && !plain_age(b)) begin
				b = 8'h61;
			end
			mix_byte(b);
		end
	endtask

	// Tag the top two bytes with the age codes of a prefixed clip name
	function automatic logic [63:0] clip_tag();
		logic [63:0] h;
		logic        xdef;
		logic        ydef;
		logic [7:0]  px;
		logic [7:0]  py;
		h = acc;
		if (kind == fnvh_pkg::KIND_UNDEC || kind == fnvh_pkg::KIND_NONE) begin
			return h;
		end
		xdef = plain_age(pfx[0]);
		ydef = (kind == fnvh_pkg::KIND_XY) ? plain_age(pfx[2]) : 1'b1;
		if (xdef && ydef) begin
			h[63] = 1'b0;
			return h;
		end
		h[63] = 1'b1;
		px = xdef ? 8'h00 : age_tag(pfx[0]);
		py = (kind == fnvh_pkg::KIND_XY && !ydef) ? age_tag(pfx[2]) : 8'h00;
		h[63:56] = h[63:56] ^ px;
		h[55:48] = h[55:48] ^ py;
		return h;
	endfunction

	task automatic take_word(input logic [7:0] din, input logic hb, input logic lst);
		logic [1:0]  m;
		logic [7:0]  b;
		logic [63:0] r;
		m = live_mode(mode_q);
		if (hb) begin
			b = din;
			if (m == fnvh_pkg::MODE_CLIP) begin
				b = fold_lc(b);
				if (kind == fnvh_pkg::KIND_UNDEC && nbytes < 3'd4) begin
					pfx[nbytes[1:0]] = b;
					nbytes = nbytes + 3'd1;
					if (nbytes == 3'd4) begin
						settle_prefix();
					end
				end else begin
					mix_byte(b);
				end
			end else begin
				if (fold_q) begin
					b = fold_lc(b);
				end
				mix_byte(b);
			end
		end
		if (lst) begin
			if (m == fnvh_pkg::MODE_CLIP) begin
				if (kind == fnvh_pkg::KIND_UNDEC) begin
					settle_prefix();
				end
				r = clip_tag();
			end else if (m == fnvh_pkg::MODE_32) begin
				r = {32'd0, acc[31:0]};
			end else begin
				r = acc;
			end
			hash_fifo = {hash_fifo, r};
			restart_name();
		end
	endtask

	// Compare outputs first, then apply register writes and input words
	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		if (!arst_n) begin
			mode_q = fnvh_pkg::MODE_64;
			fold_q = 1'b0;
			restart_name();
			hash_fifo.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (hash_fifo.size() == 0) begin
					if (fail_count < 10) begin
						$display("%0t: unexpected hash word %h", $time, hash_value);
					end
					fail_count++;
				end else begin
					want = hash_fifo.pop_front();
					if (hash_value !== want) begin
						if (fail_count < 10) begin
							$display("%0t: hash_value mismatch, expected %h got %h",
								$time, want, hash_value);
						end
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == fnvh_pkg::REG_HASH_MODE) begin
					mode_q = cfg_data;
					restart_name();
				end else begin
					fold_q = cfg_data[0];
				end
			end
			if (in_valid && in_ready) begin
				take_word(data_byte, has_byte, is_last);
			end
		end
		hashes_due = hash_fifo.size();
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression bench for the FNV-1 string hash engine: directed names for the
// corner cases, then random names over all modes and fold settings with
// random idling on both channels; the checker does all scoring.
// ----------------------------------------------------------------------------
module tb;

	localparam int PHASES      = 16;
	localparam int PHASE_WORDS = 108;
	localparam int SETTLE      = 24;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_LEN    = 400;
	// Mode per phase, phase 0 in the low bits
	localparam logic [31:0] MODE_PLAN = {
		fnvh_pkg::MODE_32, fnvh_pkg::MODE_CLIP, fnvh_pkg::MODE_64, fnvh_pkg::MODE_CLIP,
		fnvh_pkg::MODE_ALT, fnvh_pkg::MODE_32, fnvh_pkg::MODE_CLIP, fnvh_pkg::MODE_64,
		fnvh_pkg::MODE_CLIP, fnvh_pkg::MODE_32, fnvh_pkg::MODE_CLIP, fnvh_pkg::MODE_ALT,
		fnvh_pkg::MODE_CLIP, fnvh_pkg::MODE_64, fnvh_pkg::MODE_32, fnvh_pkg::MODE_CLIP
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        has_byte;
	logic        is_last;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] hash_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [1:0]  cfg_data;

	int fail_count;
	int hashes_due;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_cycles    = 0;
	int quiet_cycles   = 0;
	int words_sent     = 0;

	logic [7:0] name_buf [$];

	fnv1_string_hash_engine u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.has_byte   (has_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	fnv1_hash_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.has_byte   (has_byte),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.hashes_due (hashes_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Output side: a requested hold-off wins, otherwise stall at random
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Abort when no channel moves a word for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("fnv1_string_hash_engine regression: fail");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0, 1, 2: return 8'(fnvh_pkg::CH_A + $urandom_range(25));
			3, 4:    return 8'(fnvh_pkg::CH_UP_A + $urandom_range(25));
			5:       return fnvh_pkg::CH_US;
			6:       return fnvh_pkg::CH_TWO;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] age_letter();
		logic [7:0] c;
		case ($urandom_range(9))
			0:       c = fnvh_pkg::CH_A;
			1:       c = fnvh_pkg::CH_O;
			2:       c = fnvh_pkg::CH_B;
			3:       c = fnvh_pkg::CH_P;
			4:       c = fnvh_pkg::CH_C;
			5:       c = fnvh_pkg::CH_T;
			6:       c = fnvh_pkg::CH_H;
			7:       c = fnvh_pkg::CH_E;
			default: c = 8'(fnvh_pkg::CH_A + $urandom_range(25));
		endcase
		// upper case now and then, the block folds it
		if ($urandom_range(3) == 0) begin
			c = c - 8'h20;
		end
		return c;
	endfunction

	// Offer one word; valid stays up across back-to-back words
	task automatic send_word(input logic [7:0] b, input logic hb, input logic lst);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		has_byte  <= hb;
		is_last   <= lst;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// Send name_buf with idle words sprinkled in; end it on the last byte or
	// with a separate empty last word
	task automatic send_name(input bit split_last);
		for (int i = 0; i < name_buf.size(); i++) begin
			if ($urandom_range(19) == 0) begin
				send_word(8'($urandom_range(255)), 1'b0, 1'b0);
			end
			send_word(name_buf[i], 1'b1, (i == name_buf.size() - 1) && !split_last);
		end
		if (split_last || name_buf.size() == 0) begin
			send_word(8'($urandom_range(255)), 1'b0, 1'b1);
		end
	endtask

	// Stop offering, wait for every hash due, then let the pipe go quiet
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (hashes_due != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [1:0] plan_mode;
		logic       fold_sel;
		int         tail;
		bit         paused;
		in_valid  = 1'b0;
		data_byte = 8'h00;
		has_byte  = 1'b0;
		is_last   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data  = 2'd0;
		paused    = 1'b0;
		arst_n    = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 64-bit, no folding; empty name, idle word, byte extremes
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'hA5, 1'b0, 1'b0);
		name_buf = '{8'h00, 8'hFF};
		send_name(1'b0);
		drain();

		// 32-bit with folding: letter range edges and their neighbors
		write_reg(fnvh_pkg::REG_FOLD_CASE, 2'b01);
		write_reg(fnvh_pkg::REG_HASH_MODE, fnvh_pkg::MODE_32);
		name_buf = '{fnvh_pkg::CH_UP_A, fnvh_pkg::CH_UP_Z, 8'h40, 8'h5B};
		send_name(1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		drain();

		// Clip names: two-age prefix with tail, one-age short name, untagged ages,
		// single byte, empty name, non-ASCII head
		write_reg(fnvh_pkg::REG_HASH_MODE, fnvh_pkg::MODE_CLIP);
		name_buf = '{8'h42, fnvh_pkg::CH_TWO, fnvh_pkg::CH_E, fnvh_pkg::CH_US, 8'h78};
		send_name(1'b0);
		name_buf = '{fnvh_pkg::CH_T, fnvh_pkg::CH_US};
		send_name(1'b0);
		name_buf = '{fnvh_pkg::CH_O, fnvh_pkg::CH_TWO, fnvh_pkg::CH_A, fnvh_pkg::CH_US};
		send_name(1'b0);
		name_buf = '{8'h51};
		send_name(1'b0);
		send_word(8'h00, 1'b0, 1'b1);
		name_buf = '{8'hE1, fnvh_pkg::CH_US};
		send_name(1'b0);
		// leave a name open, the mode write drops it
		send_word(fnvh_pkg::CH_B, 1'b1, 1'b0);
		drain();

		// Mode value three runs as 64-bit
		write_reg(fnvh_pkg::REG_HASH_MODE, fnvh_pkg::MODE_ALT);
		name_buf = '{8'h6B};
		send_name(1'b0);
		drain();

		// Random phases over modes, folding and idling
		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			plan_mode = MODE_PLAN[2*p +: 2];
			fold_sel = p[0] ^ p[1] ^ p[2];
			write_reg(fnvh_pkg::REG_FOLD_CASE, {1'($urandom_range(1)), fold_sel});
			write_reg(fnvh_pkg::REG_HASH_MODE, plan_mode);
			// hold the output off while names keep coming, so the input backs up
			if (p == 4) begin
				hold_cycles = HOLD_LEN;
			end
			words_sent = 0;
			while (words_sent < PHASE_WORDS) begin
				name_buf.delete();
				if (plan_mode == fnvh_pkg::MODE_CLIP && $urandom_range(9) < 7) begin
					name_buf = {name_buf, age_letter()};
					if ($urandom_range(1)) begin
						name_buf = {name_buf, fnvh_pkg::CH_TWO};
						name_buf = {name_buf, age_letter()};
					end
					name_buf = {name_buf, fnvh_pkg::CH_US};
				end
				tail = ($urandom_range(15) == 0) ? $urandom_range(24, 7) : $urandom_range(6);
				repeat (tail) name_buf = {name_buf, pick_byte()};
				send_name($urandom_range(9) == 0);
				// pause once until the output side has caught up
				if (p == 9 && !paused && words_sent >= PHASE_WORDS / 2) begin
					paused = 1'b1;
					drain();
				end
			end
			// leave a partial name behind for the next mode write to drop
			if (p % 3 == 1) begin
				repeat ($urandom_range(3, 1)) send_word(pick_byte(), 1'b1, 1'b0);
			end
			drain();
		end

		if (fail_count == 0 && hashes_due == 0) begin
			$display("fnv1_string_hash_engine regression: pass");
		end else begin
			$display("fnv1_string_hash_engine regression: fail");
		end
		$finish;
	end

endmodule
